// ===== rtl/pyl_pkg.sv =====
// Shared types for the Python-like lexer: token kinds, token and result
// records, the record passed from the scanner to the result queue, and the
// queue status record. No dependencies.
package pyl_pkg;

   typedef enum logic [3:0] {
      KIND_EOL      = 4'd0,
      KIND_PLUS     = 4'd1,
      KIND_MINUS    = 4'd2,
      KIND_MUL      = 4'd3,
      KIND_DIV      = 4'd4,
      KIND_ASSIGN   = 4'd5,
      KIND_LPAREN   = 4'd6,
      KIND_RPAREN   = 4'd7,
      KIND_KEYWORD  = 4'd8,
      KIND_IDENT    = 4'd9,
      KIND_INT      = 4'd10,
      KIND_DOUBLE   = 4'd11,
      KIND_STR_END  = 4'd12,
      KIND_STR_BYTE = 4'd13,
      KIND_EOF      = 4'd14,
      KIND_ERROR    = 4'd15
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] kw_index;
      logic [7:0] str_byte;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } result_type;

   // Tokens produced by one accepted transaction, first in order first.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

   typedef struct packed {
      logic       valid;
      logic       ready;
      logic [1:0] fill;
   } queue_status_type;

endpackage

// ===== rtl/pyl_if.sv =====
// Handshake channels of the lexer: source bytes in, tokens out.
// No dependencies.
interface pyl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface pyl_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [2:0] keyword_index;
   logic [7:0] string_byte;
   logic       last_result;

   modport source (output valid, output token_kind, output keyword_index,
                   output string_byte, output last_result, input ready);
   modport sink (input valid, input token_kind, input keyword_index,
                 input string_byte, input last_result, output ready);
endinterface

// ===== rtl/python_like_lexer_unit.sv =====
// Lexer for a small Python-like language. One source byte or end mark is
// taken per clock cycle; each yields zero, one or two tokens, which are
// registered in the result queue before they reach the result channel. Tokens wait
// in a three-entry queue, and the input is held off while two or more
// tokens are waiting. A byte that produces two tokens (a terminator after
// an identifier or number, or an unknown string escape) therefore holds
// the input off for the following cycle even while the result side drains,
// and for longer while the result side stalls. The scanner state updates
// in the same cycle as the transaction, so bytes that produce at most one
// token flow at one per cycle while the result side takes one token per
// cycle.
// Depends on pyl_pkg, pyl_if, pyl_scan and pyl_rsp_queue.
module python_like_lexer_unit
   import pyl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   pyl_req_if.sink     req_bus,
   pyl_rsp_if.source   rsp_bus
);

   logic             accept;
   logic             pop;
   scan_out_type     scan_out;
   result_type       head;
   queue_status_type q_status;

   assign accept = req_bus.valid & req_bus.ready;
   assign pop    = rsp_bus.valid & rsp_bus.ready;

   pyl_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_byte    (req_bus.char_byte),
      .end_of_input (req_bus.end_of_input),
      .scan_out     (scan_out)
   );

   pyl_rsp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (scan_out),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   assign req_bus.ready         = q_status.ready;
   assign rsp_bus.valid         = q_status.valid;
   assign rsp_bus.token_kind    = head.tok.kind;
   assign rsp_bus.keyword_index = head.tok.kw_index;
   assign rsp_bus.string_byte   = head.tok.str_byte;
   assign rsp_bus.last_result   = head.last;

`ifndef SYNTHESIS
   // The scanner never produces more than two tokens per transaction.
   assert property (@(posedge clock) disable iff (reset) scan_out.count != 2'd3)
      else $error("scanner reported three tokens");

   // A token that is not the last of its transaction has its partner queued.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_bus.valid && !rsp_bus.last_result |-> q_status.fill >= 2'd2)
      else $error("first of a token pair queued without its partner");

   // Only string byte tokens carry a byte.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_bus.valid && (head.tok.kind != KIND_STR_BYTE)
                    |-> rsp_bus.string_byte == 8'h00)
      else $error("string byte set on a token of another kind");

   // A transaction that yields no token cannot grow the queue.
   assert property (@(posedge clock) disable iff (reset)
                    accept && (scan_out.count == 2'd0) |=> q_status.fill <= $past(q_status.fill))
      else $error("queue grew without tokens");
`endif

endmodule

// ===== rtl/pyl_scan.sv =====
// Scanner of the lexer: holds the scanner state and decides, for each
// accepted byte or end mark, the next state and up to two tokens.
// Depends on pyl_pkg.
module pyl_scan
   import pyl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   char_byte,
   input  logic         end_of_input,
   output scan_out_type scan_out
);

   typedef enum logic [17:0] {
      ST_START    = 18'd1,
      ST_LINECMT  = 18'd2,
      ST_OPEN1    = 18'd4,
      ST_OPEN2    = 18'd8,
      ST_BODY     = 18'd16,
      ST_CLOSE1   = 18'd32,
      ST_CLOSE2   = 18'd64,
      ST_IDENT    = 18'd128,
      ST_INT      = 18'd256,
      ST_POINT    = 18'd512,
      ST_FRAC     = 18'd1024,
      ST_EXP      = 18'd2048,
      ST_EXPSIGN  = 18'd4096,
      ST_EXPDIG   = 18'd8192,
      ST_STR      = 18'd16384,
      ST_ESC      = 18'd32768,
      ST_HEX1     = 18'd65536,
      ST_HEX2     = 18'd131072
   } state_type;

   localparam int KW_COUNT = 7;
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd6, 3'd5};
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "o", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "a", "s", "s", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_UPPER_E    = 8'h45;
   localparam logic [7:0] CH_BSLASH     = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_E    = 8'h65;
   localparam logic [7:0] CH_LOWER_N    = 8'h6E;
   localparam logic [7:0] CH_LOWER_T    = 8'h74;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] MIN_PRINTABLE = 8'd32;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= "0") && (ch <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
   endfunction

   // Valid flag in the top bit, nibble value below.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [7:0] diff;
      diff = 8'h00;
      if (is_digit(ch)) begin
         diff = ch - 8'h30;
         return {1'b1, diff[3:0]};
      end else if ((ch >= "a") && (ch <= "f")) begin
         diff = ch - 8'h57;
         return {1'b1, diff[3:0]};
      end else if ((ch >= "A") && (ch <= "F")) begin
         diff = ch - 8'h37;
         return {1'b1, diff[3:0]};
      end
      return 5'b0_0000;
   endfunction

   // Drops every keyword that no longer agrees with the identifier.
   function automatic logic [6:0] match_next(input logic [6:0] m, input logic [2:0] p,
                                             input logic [7:0] ch);
      logic [6:0] r;
      r = m;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (m[k] && ((p >= KW_LEN[k]) || (KW_TEXT[k][p] != ch))) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic token_type make_token(input kind_type kind, input logic [7:0] sb);
      token_type t;
      t.kind     = kind;
      t.kw_index = 3'd0;
      t.str_byte = sb;
      return t;
   endfunction

   function automatic token_type ident_token(input logic [6:0] m, input logic [2:0] len);
      token_type t;
      logic      found;
      t     = make_token(KIND_IDENT, 8'h00);
      found = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!found && m[k] && (KW_LEN[k] == len)) begin
            found      = 1'b1;
            t.kind     = KIND_KEYWORD;
            t.kw_index = 3'(k);
         end
      end
      return t;
   endfunction

   state_type  state_ff, state_in;
   logic [6:0] match_ff, match_in;
   logic [2:0] len_ff, len_in;
   logic       zero_ff, zero_in;
   logic [1:0] digits_ff, digits_in;
   logic [3:0] hex_ff, hex_in;

   // Start-state decision for the current byte.
   state_type  fs_state;
   logic       fs_valid;
   token_type  fs_tok;
   logic       fs_ident;
   logic       fs_number;

   logic       take_fs;
   logic       pre_valid;
   token_type  pre_tok;
   logic       main_valid;
   token_type  main_tok;
   logic       c_digit;
   logic       c_word;
   logic       c_exp;
   logic [4:0] c_hex;
   logic [2:0] len_sat;
   token_type  number_tok;

   assign c_digit = is_digit(char_byte);
   assign c_word  = is_alpha(char_byte) || c_digit || (char_byte == CH_UNDERSCORE);
   assign c_exp   = (char_byte == CH_LOWER_E) || (char_byte == CH_UPPER_E);
   assign c_hex   = hex_value(char_byte);
   assign len_sat = (len_ff == 3'd7) ? len_ff : len_ff + 3'd1;

   always_comb begin
      fs_state  = ST_START;
      fs_valid  = 1'b0;
      fs_tok    = make_token(KIND_ERROR, 8'h00);
      fs_ident  = 1'b0;
      fs_number = 1'b0;
      if (end_of_input) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_EOF, 8'h00);
      end else if (char_byte == CH_NEWLINE) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_EOL, 8'h00);
      end else if (char_byte == CH_HASH) begin
         fs_state = ST_LINECMT;
      end else if (char_byte == CH_DQUOTE) begin
         fs_state = ST_OPEN1;
      end else if (char_byte == CH_SQUOTE) begin
         fs_state = ST_STR;
      end else if (is_alpha(char_byte) || (char_byte == CH_UNDERSCORE)) begin
         fs_state = ST_IDENT;
         fs_ident = 1'b1;
      end else if (c_digit) begin
         fs_state  = ST_INT;
         fs_number = 1'b1;
      end else if (char_byte == CH_LPAREN) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_LPAREN, 8'h00);
      end else if (char_byte == CH_RPAREN) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_RPAREN, 8'h00);
      end else if (char_byte == CH_EQUAL) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_ASSIGN, 8'h00);
      end else if (char_byte == CH_PLUS) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_PLUS, 8'h00);
      end else if (char_byte == CH_MINUS) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_MINUS, 8'h00);
      end else if (char_byte == CH_STAR) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_MUL, 8'h00);
      end else if (char_byte == CH_SLASH) begin
         fs_valid = 1'b1;
         fs_tok   = make_token(KIND_DIV, 8'h00);
      end else if ((char_byte == CH_SPACE) ||
                   ((char_byte >= CH_TAB) && (char_byte <= CH_CR))) begin
         fs_valid = 1'b0;
      end else begin
         fs_valid = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      match_in   = match_ff;
      len_in     = len_ff;
      zero_in    = zero_ff;
      digits_in  = digits_ff;
      hex_in     = hex_ff;
      take_fs    = 1'b0;
      pre_valid  = 1'b0;
      pre_tok    = make_token(KIND_ERROR, 8'h00);
      main_valid = 1'b0;
      main_tok   = make_token(KIND_ERROR, 8'h00);
      // A number with a leading zero and a second integer digit is an error.
      number_tok = make_token((zero_ff && (digits_ff >= 2'd2)) ? KIND_ERROR :
                              (state_ff == ST_INT) ? KIND_INT : KIND_DOUBLE, 8'h00);

      unique case (state_ff)
         ST_LINECMT: begin
            if (end_of_input || (char_byte == CH_NEWLINE)) begin
               take_fs = 1'b1;
            end
         end
         ST_OPEN1, ST_OPEN2: begin
            if (!end_of_input && (char_byte == CH_DQUOTE)) begin
               state_in = (state_ff == ST_OPEN1) ? ST_OPEN2 : ST_BODY;
            end else begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_BODY: begin
            if (end_of_input) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else if (char_byte == CH_DQUOTE) begin
               state_in = ST_CLOSE1;
            end
         end
         ST_CLOSE1: begin
            if (end_of_input) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else begin
               state_in = (char_byte == CH_DQUOTE) ? ST_CLOSE2 : ST_BODY;
            end
         end
         ST_CLOSE2: begin
            if (end_of_input) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else begin
               state_in = (char_byte == CH_DQUOTE) ? ST_START : ST_BODY;
            end
         end
         ST_IDENT: begin
            if (!end_of_input && c_word) begin
               match_in = match_next(match_ff, len_ff, char_byte);
               len_in   = len_sat;
            end else begin
               pre_valid = 1'b1;
               pre_tok   = ident_token(match_ff, len_ff);
               take_fs   = 1'b1;
            end
         end
         ST_INT: begin
            if (!end_of_input && c_digit) begin
               digits_in = (digits_ff < 2'd2) ? digits_ff + 2'd1 : digits_ff;
            end else if (!end_of_input && (char_byte == CH_DOT)) begin
               state_in = ST_POINT;
            end else if (!end_of_input && c_exp) begin
               state_in = ST_EXP;
            end else begin
               pre_valid = 1'b1;
               pre_tok   = number_tok;
               take_fs   = 1'b1;
            end
         end
         ST_POINT: begin
            if (!end_of_input && c_digit) begin
               state_in = ST_FRAC;
            end else begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_FRAC: begin
            if (!end_of_input && c_digit) begin
               state_in = ST_FRAC;
            end else if (!end_of_input && c_exp) begin
               state_in = ST_EXP;
            end else begin
               pre_valid = 1'b1;
               pre_tok   = number_tok;
               take_fs   = 1'b1;
            end
         end
         ST_EXP: begin
            if (!end_of_input && c_digit) begin
               state_in = ST_EXPDIG;
            end else if (!end_of_input &&
                         ((char_byte == CH_PLUS) || (char_byte == CH_MINUS))) begin
               state_in = ST_EXPSIGN;
            end else begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_EXPSIGN: begin
            if (!end_of_input && c_digit) begin
               state_in = ST_EXPDIG;
            end else begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_EXPDIG: begin
            if (end_of_input || !c_digit) begin
               pre_valid = 1'b1;
               pre_tok   = number_tok;
               take_fs   = 1'b1;
            end
         end
         ST_STR: begin
            if (end_of_input || (char_byte < MIN_PRINTABLE)) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else if (char_byte == CH_SQUOTE) begin
               main_valid = 1'b1;
               main_tok   = make_token(KIND_STR_END, 8'h00);
               state_in   = ST_START;
            end else if (char_byte == CH_BSLASH) begin
               state_in = ST_ESC;
            end else begin
               main_valid = 1'b1;
               main_tok   = make_token(KIND_STR_BYTE, char_byte);
            end
         end
         ST_ESC: begin
            if (end_of_input || (char_byte < MIN_PRINTABLE)) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else begin
               state_in = ST_STR;
               if ((char_byte == CH_BSLASH) || (char_byte == CH_SQUOTE) ||
                   (char_byte == CH_DQUOTE)) begin
                  main_valid = 1'b1;
                  main_tok   = make_token(KIND_STR_BYTE, char_byte);
               end else if (char_byte == CH_LOWER_N) begin
                  main_valid = 1'b1;
                  main_tok   = make_token(KIND_STR_BYTE, CH_NEWLINE);
               end else if (char_byte == CH_LOWER_T) begin
                  main_valid = 1'b1;
                  main_tok   = make_token(KIND_STR_BYTE, CH_TAB);
               end else if (char_byte == CH_LOWER_X) begin
                  state_in = ST_HEX1;
               end else begin
                  // An unknown escape keeps both the backslash and the byte.
                  pre_valid  = 1'b1;
                  pre_tok    = make_token(KIND_STR_BYTE, CH_BSLASH);
                  main_valid = 1'b1;
                  main_tok   = make_token(KIND_STR_BYTE, char_byte);
               end
            end
         end
         ST_HEX1: begin
            if (end_of_input || !c_hex[4]) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else begin
               hex_in   = c_hex[3:0];
               state_in = ST_HEX2;
            end
         end
         ST_HEX2: begin
            if (end_of_input || !c_hex[4]) begin
               main_valid = 1'b1;
               state_in   = ST_START;
            end else begin
               main_valid = 1'b1;
               main_tok   = make_token(KIND_STR_BYTE, {hex_ff, c_hex[3:0]});
               state_in   = ST_STR;
            end
         end
         default: begin
            take_fs = 1'b1;
         end
      endcase

      // The byte that ends an identifier, a number or a comment, or any byte in the
      // start state, is lexed from the start state.
      if (take_fs) begin
         state_in   = fs_state;
         main_valid = fs_valid;
         main_tok   = fs_tok;
         if (fs_ident) begin
            match_in = match_next(7'h7F, 3'd0, char_byte);
            len_in   = 3'd1;
         end
         if (fs_number) begin
            zero_in   = (char_byte == "0");
            digits_in = 2'd1;
         end
      end
   end

   always_comb begin
      scan_out.count  = accept ? ({1'b0, pre_valid} + {1'b0, main_valid}) : 2'd0;
      scan_out.first  = pre_valid ? pre_tok : main_tok;
      scan_out.second = main_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_START;
         match_ff  <= 7'h7F;
         len_ff    <= 3'd0;
         zero_ff   <= 1'b0;
         digits_ff <= 2'd0;
         hex_ff    <= 4'd0;
      end else if (accept) begin
         state_ff  <= state_in;
         match_ff  <= match_in;
         len_ff    <= len_in;
         zero_ff   <= zero_in;
         digits_ff <= digits_in;
         hex_ff    <= hex_in;
      end
   end

endmodule

// ===== rtl/pyl_rsp_queue.sv =====
// Three-entry result queue of the lexer: takes up to two tokens per
// transaction and presents them one at a time. Depends on pyl_pkg.
module pyl_rsp_queue
   import pyl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  scan_out_type     push,
   input  logic             pop,
   output result_type       head,
   output queue_status_type status
);

   localparam int DEPTH = 3;

   result_type q_ff [DEPTH];
   result_type q_in [DEPTH];
   logic [1:0] fill_ff, fill_in;
   logic [1:0] base;
   result_type first_entry;
   result_type second_entry;

   assign first_entry  = '{tok: push.first, last: (push.count == 2'd1)};
   assign second_entry = '{tok: push.second, last: 1'b1};
   assign base         = fill_ff - {1'b0, pop};
   assign fill_in      = base + push.count;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (pop) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      // New tokens land right behind whatever is still waiting.
      for (int i = 0; i < DEPTH; i++) begin
         if ((push.count != 2'd0) && (2'(i) == base)) begin
            q_in[i] = first_entry;
         end
         if ((push.count == 2'd2) && (2'(i) == base + 2'd1)) begin
            q_in[i] = second_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head         = q_ff[0];
   assign status.valid = (fill_ff != 2'd0);
   assign status.ready = (fill_ff <= 2'd1);
   assign status.fill  = fill_ff;

endmodule
